/* hdl/las_pkg.sv */
package las_pkg;

  // Configuration register width and register indexes.
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  // Defaults and limits of the grid.
  localparam int GRID_RESET = 64;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MIN_DIM = 3;
  localparam int FIRST_INTERIOR = 2;

  // Rule constants for B3/S23.
  localparam int SURVIVE_LO = 2;
  localparam int BIRTH_COUNT = 3;

  // Per-cell decision travelling from the position tracker to the result stage.
  typedef struct packed {
    logic emit;
    logic last;
  } pos_info_t;

  // Next state of the window center from its 3x3 neighborhood.
  // Bit 4 is the center; the other eight bits are the neighbors.
  function automatic logic life_next(input logic [8:0] win);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        cnt = cnt + 4'(win[i]);
      end
    end
    if (win[4]) begin
      life_next = (cnt == 4'(SURVIVE_LO)) || (cnt == 4'(BIRTH_COUNT));
    end else begin
      life_next = (cnt == 4'(BIRTH_COUNT));
    end
  endfunction

endpackage

/* hdl/las_ram.sv */
module las_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the output holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/las_pos.sv */
module las_pos #(
  parameter int MaxWidth = las_pkg::MAX_WIDTH_DEF,
  parameter int MaxHeight = las_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [las_pkg::CFG_W-1:0]    grid_width_i,
  input  logic [las_pkg::CFG_W-1:0]    grid_height_i,
  input  logic                         adv_i,
  input  logic                         frame_start_i,
  output logic [$clog2(MaxHeight)-1:0] row_o,
  output logic [$clog2(MaxWidth)-1:0]  col_o,
  output las_pkg::pos_info_t           info_o
);
  import las_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int ColCW = (ColW + 1 > CFG_W) ? ColW + 1 : CFG_W;
  localparam int RowCW = (RowW + 1 > CFG_W) ? RowW + 1 : CFG_W;

  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ColCW-1:0] w_eff, w_cfg, c_ext, c_inc;
  logic [RowCW-1:0] h_eff, h_cfg, r_ext, r_inc;

  // Clamp the configured dimensions to the supported range.
  always_comb begin
    w_cfg = ColCW'(grid_width_i);
    h_cfg = RowCW'(grid_height_i);
    if (w_cfg < ColCW'(MIN_DIM)) begin
      w_eff = ColCW'(MIN_DIM);
    end else if (w_cfg > ColCW'(MaxWidth)) begin
      w_eff = ColCW'(MaxWidth);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg < RowCW'(MIN_DIM)) begin
      h_eff = RowCW'(MIN_DIM);
    end else if (h_cfg > RowCW'(MaxHeight)) begin
      h_eff = RowCW'(MaxHeight);
    end else begin
      h_eff = h_cfg;
    end
  end

  // Position of the arriving cell; a frame start forces the origin.
  assign row_o = frame_start_i ? '0 : row_q;
  assign col_o = frame_start_i ? '0 : col_q;
  assign r_ext = RowCW'(row_o);
  assign c_ext = ColCW'(col_o);

  // The interior cell one row and one column back is complete here.
  always_comb begin
    info_o.emit = (r_ext >= RowCW'(FIRST_INTERIOR)) && (r_ext < h_eff) &&
                  (c_ext >= ColCW'(FIRST_INTERIOR)) && (c_ext < w_eff);
    info_o.last = (r_ext == h_eff - RowCW'(1)) && (c_ext == w_eff - ColCW'(1));
  end

  // Raster advance with wrap at the end of a row and of a generation.
  always_comb begin
    c_inc = c_ext + ColCW'(1);
    r_inc = r_ext + RowCW'(1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      if (r_inc >= h_eff) begin
        row_d = '0;
      end else begin
        row_d = RowW'(r_inc);
      end
    end else begin
      col_d = ColW'(c_inc);
      row_d = row_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (adv_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

/* hdl/las_eval.sv */
module las_eval #(
  parameter int MaxWidth = las_pkg::MAX_WIDTH_DEF,
  parameter int MaxHeight = las_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         alive_i,
  input  logic                         up_i,
  input  logic                         mid_i,
  input  las_pkg::pos_info_t           info_i,
  input  logic [$clog2(MaxHeight)-1:0] row_i,
  input  logic [$clog2(MaxWidth)-1:0]  col_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [$clog2(MaxHeight)-1:0] out_row_o,
  output logic [$clog2(MaxWidth)-1:0]  out_col_o,
  output logic                         next_alive_o,
  output logic                         out_last_of_frame_o
);
  import las_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);

  logic [8:0]      window_q, window_d;
  logic            valid_q, valid_d;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic            next_q;
  logic            last_q;

  // Shift the newest column (upper, middle, lower) into the window.
  assign window_d = {window_q[5:0], alive_i, mid_i, up_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (adv_i) begin
      window_q <= window_d;
    end
  end

  // Result register: loads on advance, empties when taken.
  always_comb begin
    valid_d = valid_q;
    if (adv_i) begin
      valid_d = info_i.emit;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && info_i.emit) begin
      row_q  <= row_i;
      col_q  <= col_i;
      next_q <= life_next(window_d);
      last_q <= info_i.last;
    end
  end

  assign out_valid_o         = valid_q;
  assign out_row_o           = row_q;
  assign out_col_o           = col_q;
  assign next_alive_o        = next_q;
  assign out_last_of_frame_o = last_q;

endmodule

/* hdl/life_automaton_stencil_core.sv */
// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  -----------------------------------------
// in        request    in_valid_i / in_stall_o   cell_alive_i, frame_start_i
// out       result     out_valid_o / out_stall_i out_row_o, out_col_o, next_alive_o,
//                                                out_last_of_frame_o
// cfg       write      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One cell is accepted every cycle unless in_stall_o is high; each passes the input stage
// register and, if it has a result, the result register. The pace is set by the single
// row-store RAM, read at acceptance and written as the item leaves the input stage. Reset
// clears the grid size to 64x64, the position, window and valid flags; the row stores are
// not cleared and need no clearing pass. A stalled result holds the result register; a
// request is still taken while the stage behind it can move on.
module life_automaton_stencil_core #(
  parameter int MaxWidth = las_pkg::MAX_WIDTH_DEF,
  parameter int MaxHeight = las_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [las_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [las_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cell_alive_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [$clog2(MaxHeight)-1:0]  out_row_o,
  output logic [$clog2(MaxWidth)-1:0]   out_col_o,
  output logic                          next_alive_o,
  output logic                          out_last_of_frame_o
);
  import las_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);

  logic [CFG_W-1:0] grid_width_q, grid_height_q;
  logic             in_acc, s1_adv;
  logic [RowW-1:0]  pos_row;
  logic [ColW-1:0]  pos_col;
  pos_info_t        pos_info;

  logic             s1_valid_q;
  logic             s1_alive_q;
  logic [ColW-1:0]  s1_addr_q;
  logic [RowW-1:0]  s1_row_q;
  logic [ColW-1:0]  s1_col_q;
  pos_info_t        s1_info_q;
  logic             fwd_q, fwd_d;
  logic [1:0]       fwd_data_q;
  logic [1:0]       ram_rdata, s1_rows, s1_wdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_W'(GRID_RESET);
      grid_height_q <= CFG_W'(GRID_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage takes a request when it is empty or moving on.
  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  las_pos #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grid_width_i (grid_width_q),
    .grid_height_i(grid_height_q),
    .adv_i        (in_acc),
    .frame_start_i(frame_start_i),
    .row_o        (pos_row),
    .col_o        (pos_col),
    .info_o       (pos_info)
  );

  // Both row stores share one RAM: bit 0 is the upper row, bit 1 the middle row.
  las_ram #(
    .Width(2),
    .Depth(MaxWidth)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_addr_q),
    .wdata_i(s1_wdata),
    .re_i   (in_acc),
    .raddr_i(pos_col),
    .rdata_o(ram_rdata)
  );

  // A read of the column being written in the same cycle takes the new data.
  assign fwd_d    = s1_adv && (s1_addr_q == pos_col);
  assign s1_rows  = fwd_q ? fwd_data_q : ram_rdata;
  assign s1_wdata = {s1_alive_q, s1_rows[1]};

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      fwd_q      <= fwd_d;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_alive_q <= cell_alive_i;
      s1_addr_q  <= pos_col;
      s1_row_q   <= pos_row - RowW'(1);
      s1_col_q   <= pos_col - ColW'(1);
      s1_info_q  <= pos_info;
      fwd_data_q <= s1_wdata;
    end
  end

  las_eval #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_eval (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .adv_i              (s1_adv),
    .alive_i            (s1_alive_q),
    .up_i               (s1_rows[0]),
    .mid_i              (s1_rows[1]),
    .info_i             (s1_info_q),
    .row_i              (s1_row_q),
    .col_i              (s1_col_q),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_row_o          (out_row_o),
    .out_col_o          (out_col_o),
    .next_alive_o       (next_alive_o),
    .out_last_of_frame_o(out_last_of_frame_o)
  );

`ifndef SYNTHESIS
  // Forwarded row data only ever belongs to an item held in the input stage.
  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forward flag set with empty input stage");

  // A new result comes only from an item that sat in the input stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("result appeared without a source item");

  // The column position always addresses a row-store entry.
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ((ColW + 1)'(pos_col) < (ColW + 1)'(MaxWidth)))
    else $error("column position beyond row store");

  // An emitted interior column never lands on the first column.
  a_interior_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_info.emit) |=> (s1_col_q != '0))
    else $error("interior result on border column");
`endif

endmodule
